[design/fla_pkg.sv]
// fla_pkg: shared types, constants and state codes of the free list allocator
// depends on nothing; imported by fla_fit and free_list_allocator
package fla_pkg;

   localparam int CAPACITY     = 65536;
   localparam int HEADER_BYTES = 16;
   localparam int ALIGN_BYTES  = 16;
   localparam int MAX_FREE     = 1024;
   localparam int BLOCK_SLOTS  = CAPACITY / ALIGN_BYTES;
   localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
   localparam int SLOT_BITS    = $clog2(BLOCK_SLOTS);
   localparam int EXT_AW       = $clog2(MAX_FREE);
   localparam int CNT_W        = EXT_AW + 1;

   localparam logic       FUNC_ALLOC   = 1'b0;
   localparam logic       FUNC_RELEASE = 1'b1;
   localparam logic [1:0] FIT_FIRST    = 2'd0;
   localparam logic [1:0] FIT_BEST     = 2'd1;
   localparam logic [1:0] FIT_WORST    = 2'd2;
   localparam logic       STATUS_OK    = 1'b0;
   localparam logic       STATUS_FAIL  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [15:0] req_size;
      logic [15:0] release_addr;
   } req_word_type;

   typedef struct packed {
      logic [15:0] payload_addr;
      logic        status;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] pay;
   } ext_entry_type;

   typedef struct packed {
      logic take;
      logic hit;
   } fit_result_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_REL_APPLY,
      S_SHIFT_DN,
      S_SHIFT_UP,
      S_INS,
      S_RESP
   } state_type;

endpackage

[design/fla_ram.sv]
// fla_ram: generic single write, single read memory with registered read data
// depends on nothing
module fla_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fla_fit.sv]
// fla_fit: fit compare unit, judges one free extent against the request
// depends on fla_pkg
module fla_fit import fla_pkg::*; (
   input  logic [1:0]     policy,
   input  logic [16:0]    need,
   input  logic [15:0]    pay,
   input  logic           found,
   input  logic [15:0]    pick_pay,
   output fit_result_type result
);

   logic [16:0] pay_x;
   logic        above;

   assign pay_x = {1'b0, pay};
   assign above = pay_x > need;

   always_comb begin
      result = '0;
      case (policy)
         FIT_BEST: begin
            result.hit  = pay_x == need;
            result.take = (pay_x == need) || (above && (!found || pick_pay > pay));
         end
         FIT_WORST: begin
            result.hit  = 1'b0;
            result.take = above && (!found || pick_pay < pay);
         end
         default: begin
            result.hit  = pay_x >= need;
            result.take = pay_x >= need;
         end
      endcase
   end

endmodule

[design/free_list_allocator.sv]
// free_list_allocator: top level, sequencer over the extent table and block size table
// depends on fla_pkg, fla_ram, fla_fit
//
//   channel  ports                         dir  word
//   req      req_valid req_stall req_word   in   func, req_size, release_addr
//   rsp      rsp_valid rsp_stall rsp_word   out  payload_addr, status
//   csr      csr_valid csr_ready csr_data   in   fit_policy
//
// one item at a time; the extent table is read one entry per cycle
// while scanning, then a split or a one-sided merge is a single extent write, while an
// unlink or new extent moves the table tail at one entry per cycle (up to 1024)
// a null request skips the scan and goes straight to the response
// after reset the S_INIT state writes the initial extent before req is taken
// rsp_stall holds the finished word; req stays stalled until it is loaded
module free_list_allocator import fla_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data
);

   state_type state_ff, state_in;
   logic [1:0]         policy_ff;
   logic               func_ff, func_in;
   logic [16:0]        need_ff, need_in;
   logic [15:0]        blk_ff, blk_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ins_ff, ins_in;
   logic               pv_ff, pv_in;
   logic [EXT_AW-1:0]  tag_ff, tag_in;
   logic               found_ff, found_in;
   logic [EXT_AW-1:0]  pick_idx_ff, pick_idx_in;
   ext_entry_type      pick_ff, pick_in;
   logic               prev_vld_ff, prev_vld_in;
   ext_entry_type      prev_ff, prev_in;
   logic               cur_vld_ff, cur_vld_in;
   ext_entry_type      cur_ff, cur_in;
   logic [15:0]        res_addr_ff, res_addr_in;
   logic               res_ok_ff, res_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               ext_we;
   logic [EXT_AW-1:0]  ext_waddr, ext_raddr;
   ext_entry_type      ext_wdata, ext_rdata;
   logic               bps_we;
   logic [SLOT_BITS-1:0] bps_waddr, bps_raddr;
   logic [15:0]        bps_wdata, bps_rdata;
   fit_result_type     fit;

   logic               accept;
   logic [17:0]        split_lim, rm_sum, lm_sum, both_sum, left_sum, right_sum;
   logic               rm, lm;
   logic [15:0]        rest, hdr;

   fla_ram #(.DEPTH(MAX_FREE), .WIDTH($bits(ext_entry_type))) u_ext_ram (
      .clock   (clock),
      .wr_en   (ext_we),
      .wr_addr (ext_waddr),
      .wr_data (ext_wdata),
      .rd_addr (ext_raddr),
      .rd_data (ext_rdata)
   );

   fla_ram #(.DEPTH(BLOCK_SLOTS), .WIDTH(16)) u_bps_ram (
      .clock   (clock),
      .wr_en   (bps_we),
      .wr_addr (bps_waddr),
      .wr_data (bps_wdata),
      .rd_addr (bps_raddr),
      .rd_data (bps_rdata)
   );

   fla_fit u_fit (
      .policy   (policy_ff),
      .need     (need_ff),
      .pay      (ext_rdata.pay),
      .found    (found_ff),
      .pick_pay (pick_ff.pay),
      .result   (fit)
   );

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign bps_raddr = blk_ff[ALIGN_SHIFT +: SLOT_BITS];

   // merge arithmetic for release
   assign rm_sum    = 18'(blk_ff) + 18'(HEADER_BYTES) + 18'(bps_rdata);
   assign lm_sum    = 18'(prev_ff.start) + 18'(HEADER_BYTES) + 18'(prev_ff.pay);
   assign rm        = cur_vld_ff && (rm_sum == 18'(cur_ff.start));
   assign lm        = prev_vld_ff && (lm_sum == 18'(blk_ff));
   assign both_sum  = 18'(prev_ff.pay) + 18'(2 * HEADER_BYTES) + 18'(bps_rdata)
                      + 18'(cur_ff.pay);
   assign left_sum  = 18'(prev_ff.pay) + 18'(HEADER_BYTES) + 18'(bps_rdata);
   assign right_sum = 18'(bps_rdata) + 18'(HEADER_BYTES) + 18'(cur_ff.pay);

   // split arithmetic for allocate
   assign split_lim = 18'(need_ff) + 18'(2 * HEADER_BYTES);
   assign rest      = 16'(pick_ff.pay - 16'(HEADER_BYTES) - need_ff[15:0]);
   assign hdr       = 16'(pick_ff.start + 16'(HEADER_BYTES) + rest);

   function automatic logic [15:0] sat16(input logic [17:0] v);
      sat16 = (v > 18'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         policy_ff    <= FIT_FIRST;
         count_ff     <= CNT_W'(1);
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_data;
         end
      end
      func_ff     <= func_in;
      need_ff     <= need_in;
      blk_ff      <= blk_in;
      ptr_ff      <= ptr_in;
      ins_ff      <= ins_in;
      tag_ff      <= tag_in;
      found_ff    <= found_in;
      pick_idx_ff <= pick_idx_in;
      pick_ff     <= pick_in;
      prev_vld_ff <= prev_vld_in;
      prev_ff     <= prev_in;
      cur_vld_ff  <= cur_vld_in;
      cur_ff      <= cur_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      need_in      = need_ff;
      blk_in       = blk_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      ins_in       = ins_ff;
      pv_in        = 1'b0;
      tag_in       = tag_ff;
      found_in     = found_ff;
      pick_idx_in  = pick_idx_ff;
      pick_in      = pick_ff;
      prev_vld_in  = prev_vld_ff;
      prev_in      = prev_ff;
      cur_vld_in   = cur_vld_ff;
      cur_in       = cur_ff;
      res_addr_in  = res_addr_ff;
      res_ok_in    = res_ok_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ext_we       = 1'b0;
      ext_waddr    = tag_ff;
      ext_wdata    = ext_rdata;
      ext_raddr    = ptr_ff[EXT_AW-1:0];
      bps_we       = 1'b0;
      bps_waddr    = hdr[ALIGN_SHIFT +: SLOT_BITS];
      bps_wdata    = need_ff[15:0];

      case (state_ff)
         S_INIT: begin
            ext_we          = 1'b1;
            ext_waddr       = '0;
            ext_wdata.start = '0;
            ext_wdata.pay   = 16'(CAPACITY - HEADER_BYTES);
            state_in        = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               func_in     = req_word.func;
               need_in     = (17'(req_word.req_size) + 17'(ALIGN_BYTES - 1))
                             & ~17'(ALIGN_BYTES - 1);
               blk_in      = 16'(req_word.release_addr - 16'(HEADER_BYTES));
               ptr_in      = '0;
               found_in    = 1'b0;
               prev_vld_in = 1'b0;
               cur_vld_in  = 1'b0;
               ins_in      = count_ff;
               res_addr_in = '0;
               res_ok_in   = 1'b0;
               if ((req_word.func == FUNC_ALLOC && req_word.req_size == '0) ||
                   (req_word.func == FUNC_RELEASE && req_word.release_addr == '0)) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ptr_ff < count_ff) begin
               pv_in  = 1'b1;
               tag_in = ptr_ff[EXT_AW-1:0];
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (pv_ff) begin
               if (func_ff == FUNC_ALLOC) begin
                  if (fit.take) begin
                     found_in    = 1'b1;
                     pick_idx_in = tag_ff;
                     pick_in     = ext_rdata;
                  end
                  if (fit.hit) begin
                     state_in = S_ALLOC;
                  end
               end else if (ext_rdata.start < blk_ff) begin
                  prev_vld_in = 1'b1;
                  prev_in     = ext_rdata;
               end else begin
                  cur_vld_in = 1'b1;
                  cur_in     = ext_rdata;
                  ins_in     = CNT_W'(tag_ff);
                  state_in   = S_REL_APPLY;
               end
            end else if (ptr_ff >= count_ff) begin
               if (func_ff == FUNC_RELEASE) begin
                  state_in = S_REL_APPLY;
               end else if (found_ff) begin
                  state_in = S_ALLOC;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_ALLOC: begin
            res_ok_in = 1'b1;
            bps_we    = 1'b1;
            if (18'(pick_ff.pay) >= split_lim) begin
               ext_we          = 1'b1;
               ext_waddr       = pick_idx_ff;
               ext_wdata.start = pick_ff.start;
               ext_wdata.pay   = rest;
               res_addr_in     = 16'(hdr + 16'(HEADER_BYTES));
               state_in        = S_RESP;
            end else begin
               bps_waddr   = pick_ff.start[ALIGN_SHIFT +: SLOT_BITS];
               bps_wdata   = pick_ff.pay;
               res_addr_in = 16'(pick_ff.start + 16'(HEADER_BYTES));
               ptr_in      = CNT_W'(pick_idx_ff);
               state_in    = S_SHIFT_DN;
            end
         end
         S_REL_APPLY: begin
            res_ok_in = 1'b1;
            state_in  = S_RESP;
            if (lm && rm) begin
               ext_we          = 1'b1;
               ext_waddr       = EXT_AW'(ins_ff - CNT_W'(1));
               ext_wdata.start = prev_ff.start;
               ext_wdata.pay   = sat16(both_sum);
               ptr_in          = ins_ff;
               state_in        = S_SHIFT_DN;
            end else if (lm) begin
               ext_we          = 1'b1;
               ext_waddr       = EXT_AW'(ins_ff - CNT_W'(1));
               ext_wdata.start = prev_ff.start;
               ext_wdata.pay   = sat16(left_sum);
            end else if (rm) begin
               ext_we          = 1'b1;
               ext_waddr       = EXT_AW'(ins_ff);
               ext_wdata.start = blk_ff;
               ext_wdata.pay   = sat16(right_sum);
            end else if (count_ff >= CNT_W'(MAX_FREE)) begin
               res_ok_in = 1'b0;
            end else begin
               ptr_in   = count_ff;
               state_in = S_SHIFT_UP;
            end
         end
         S_SHIFT_DN: begin
            ext_raddr = EXT_AW'(ptr_ff + CNT_W'(1));
            if (pv_ff) begin
               ext_we = 1'b1;
            end
            if (ptr_ff + CNT_W'(1) < count_ff) begin
               pv_in  = 1'b1;
               tag_in = ptr_ff[EXT_AW-1:0];
               ptr_in = ptr_ff + CNT_W'(1);
            end else if (!pv_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_SHIFT_UP: begin
            ext_raddr = EXT_AW'(ptr_ff - CNT_W'(1));
            if (pv_ff) begin
               ext_we = 1'b1;
            end
            if (ptr_ff > ins_ff) begin
               pv_in  = 1'b1;
               tag_in = ptr_ff[EXT_AW-1:0];
               ptr_in = ptr_ff - CNT_W'(1);
            end else if (!pv_ff) begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            ext_we          = 1'b1;
            ext_waddr       = EXT_AW'(ins_ff);
            ext_wdata.start = blk_ff;
            ext_wdata.pay   = bps_rdata;
            count_in        = count_ff + CNT_W'(1);
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.payload_addr = res_ok_ff ? res_addr_ff : 16'd0;
               rsp_word_in.status       = res_ok_ff ? STATUS_OK : STATUS_FAIL;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FREE))
      else $error("extent count above table size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("word taken while a word is in work");

   a_fail_null_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_FAIL |-> rsp_word.payload_addr == 16'd0)
      else $error("failed word carries an address");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && rsp_valid_ff && rsp_stall |=> state_ff == S_RESP)
      else $error("result lost while output held");

endmodule
